>>> rtl/closed_bspline_evaluator_defines.svh
// ----------------------------------------------------------------------------
// Closed B-spline evaluator assertion macros
// Shared concurrent assertion forms for the evaluator RTL.
// ----------------------------------------------------------------------------
`ifndef CLOSED_BSPLINE_EVALUATOR_DEFINES_SVH
`define CLOSED_BSPLINE_EVALUATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define CBS_ASSERT_NOW(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CBS_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/cbs_pkg.sv
// ----------------------------------------------------------------------------
// Closed B-spline evaluator package
// Word types, command codes and fixed constants of the evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbs_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    typedef struct packed {
        logic               command;
        logic [5:0]         point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [15:0]        phase;
        logic signed [31:0] height;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] slope_x;
        logic signed [31:0] slope_y;
        logic               curve_valid;
    } out_word_t;

    // floor(2^48 / 3) and floor(4 * 2^48 / 3)
    localparam logic [51:0] K_ONE  = 52'd93824992236885;
    localparam logic [51:0] K_FOUR = 52'd375299968947541;
    // (2^24 - 1) / 3, exact
    localparam logic [22:0] INV3_24 = 23'd5592405;
    // ceil(2^27 / 3), exact quotient for values below 2^27
    localparam logic [25:0] RECIP3_27 = 26'd44739243;
    // round(2^31 / (2 pi))
    localparam logic signed [47:0] INV_TWO_PI = 48'sd341782638;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'h7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/cbs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/closed_bspline_evaluator.sv
// ----------------------------------------------------------------------------
// Closed uniform cubic B-spline evaluator
// Control point ring plus an eight-stage evaluation pipeline.
// ----------------------------------------------------------------------------
// The block takes one word per cycle when not held by back-pressure. A write
// word stores one control point and gives no result; an evaluate word gives
// one result from the eighth stage, the output register. The four neighboring
// points are read in the accept cycle from four copies of the point RAM, so
// the accept cycle sets the one-word-per-cycle rate; everything after it is
// a stall-aware pipeline whose stages squeeze out bubbles independently.
// points_in_use is taken from cfg_wr_en / cfg_wr_data and must only change
// while no evaluate word is in flight.
`timescale 1ns / 1ps

module closed_bspline_evaluator #(
    parameter int MAX_POINTS = 64,
    parameter int PHASE_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [6:0]          cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  cbs_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cbs_pkg::out_word_t  m_data
);

`include "closed_bspline_evaluator_defines.svh"

    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int PW  = PHASE_BITS;
    localparam int NST = 8;

    // ------------------------------------------------------------------
    // points_in_use, clamped to the ring depth on write
    // ------------------------------------------------------------------
    logic [NW-1:0] n_reg, n_next;
    logic          cv_reg, cv_next;

    always_comb begin
        if (32'(cfg_wr_data) > MAX_POINTS) begin
            n_next = NW'(MAX_POINTS);
        end else begin
            n_next = NW'(cfg_wr_data);
        end
        cv_next = (32'(n_next) >= 32'd3);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg  <= '0;
            cv_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            n_reg  <= n_next;
            cv_reg <= cv_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: stage k loads when it is empty or stage k+1
    // loads. The output register is stage NST.
    // ------------------------------------------------------------------
    logic [NST:1]   v_reg, v_next;
    logic [NST+1:1] en;
    logic           acc, acc_eval, acc_wr;
    logic [31:0]    pidx;

    always_comb begin
        en[NST+1] = m_ready;
        for (int k = NST; k >= 1; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_ready  = en[1];
    assign m_valid  = v_reg[NST];
    assign acc      = s_valid && s_ready;
    assign acc_eval = acc && (s_data.command == cbs_pkg::CMD_EVAL);
    assign pidx     = 32'(s_data.point_index);
    assign acc_wr   = acc && (s_data.command == cbs_pkg::CMD_WRITE) && (pidx < MAX_POINTS);

    always_comb begin
        v_next[1] = en[1] ? acc_eval : v_reg[1];
        for (int k = 2; k <= NST; k++) begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    // ------------------------------------------------------------------
    // Accept cycle: segment, fraction and the four wrapped neighbor
    // addresses. The RAM read is issued on the accept edge itself, so a
    // later write can never overtake an earlier evaluate word.
    // ------------------------------------------------------------------
    logic [PW-1:0]    pm;
    logic [PW+NW-1:0] prod;
    logic [NW-1:0]    seg;
    logic [PW+15:0]   fwide;
    logic [15:0]      f0;
    logic [NW:0]      seg1, seg2, nx;
    logic [NW-1:0]    nb [4];
    logic [NW:0]      seg2w;

    assign pm    = PW'(s_data.phase);
    assign prod  = (PW+NW)'(pm) * (PW+NW)'(n_reg);
    assign seg   = prod[PW+NW-1:PW];
    assign fwide = {prod[PW-1:0], 16'b0} >> PW;
    assign f0    = fwide[15:0];
    assign seg1  = {1'b0, seg} + (NW+1)'(1);
    assign seg2  = {1'b0, seg} + (NW+1)'(2);
    assign nx    = {1'b0, n_reg};
    assign seg2w = (seg2 >= nx) ? (seg2 - nx) : seg2;

    always_comb begin
        nb[0] = (seg == '0) ? (n_reg - NW'(1)) : (seg - NW'(1));
        nb[1] = seg;
        nb[2] = (seg1 == nx) ? '0 : seg1[NW-1:0];
        nb[3] = seg2w[NW-1:0];
    end

    logic [63:0] rd_data [4];

    for (genvar g = 0; g < 4; g++) begin : g_ring
        cbs_ram #(
            .WIDTH (64),
            .DEPTH (MAX_POINTS)
        ) u_ring (
            .clk   (aclk),
            .we    (acc_wr),
            .waddr (pidx[AW-1:0]),
            .wdata ({s_data.point_x, s_data.point_y}),
            .re    (acc_eval),
            .raddr (nb[g][AW-1:0]),
            .rdata (rd_data[g])
        );
    end

    // ------------------------------------------------------------------
    // Stage 1: fraction and height; RAM data lands alongside
    // ------------------------------------------------------------------
    logic [15:0]        f1_reg;
    logic signed [31:0] z1_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            f1_reg <= f0;
            z1_reg <= s_data.height;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: f squared, capture points
    // ------------------------------------------------------------------
    logic [15:0]        f2_reg;
    logic signed [31:0] z2_reg;
    logic [31:0]        sq2_reg, sq2_next;
    logic signed [31:0] px2_reg [4];
    logic signed [31:0] py2_reg [4];

    assign sq2_next = 32'(f1_reg) * 32'(f1_reg);

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            f2_reg  <= f1_reg;
            z2_reg  <= z1_reg;
            sq2_reg <= sq2_next;
            for (int k = 0; k < 4; k++) begin
                px2_reg[k] <= rd_data[k][63:32];
                py2_reg[k] <= rd_data[k][31:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: f cubed, derivative weights (units of 2^-33)
    // ------------------------------------------------------------------
    logic [15:0]        f3_reg;
    logic signed [31:0] z3_reg;
    logic [31:0]        sq3_reg;
    logic [47:0]        cube3_reg, cube3_next;
    logic signed [31:0] px3_reg [4];
    logic signed [31:0] py3_reg [4];
    logic signed [31:0] c3_reg [4];
    logic signed [31:0] c3_next [4];
    logic signed [36:0] fe, se, g2;
    logic signed [36:0] dv [4];

    assign cube3_next = 48'(sq2_reg) * 48'(f2_reg);

    always_comb begin
        fe = $signed({21'b0, f2_reg});
        se = $signed({5'b0, sq2_reg});
        // (1 - t)^2 scaled, from f^2 without another multiply
        g2 = 37'sd4294967296 - (fe <<< 17) + se;
        dv[0] = -g2;
        dv[1] = se + (se <<< 1) - (fe <<< 18);
        dv[2] = 37'sd4294967296 - se - (se <<< 1) + (fe <<< 17);
        dv[3] = se;
        for (int k = 0; k < 4; k++) begin
            c3_next[k] = 32'((dv[k] + 37'sd4) >>> 3);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            f3_reg    <= f2_reg;
            z3_reg    <= z2_reg;
            sq3_reg   <= sq2_reg;
            cube3_reg <= cube3_next;
            for (int k = 0; k < 4; k++) begin
                px3_reg[k] <= px2_reg[k];
                py3_reg[k] <= py2_reg[k];
                c3_reg[k]  <= c3_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: f^3 / 3 split as hi*(2^24-1)/3 + (hi+lo)/3;
    // derivative products
    // ------------------------------------------------------------------
    logic [15:0]        f4_reg;
    logic signed [31:0] z4_reg;
    logic [31:0]        sq4_reg;
    logic [47:0]        cube4_reg;
    logic [46:0]        mh4_reg, mh4_next;
    logic [23:0]        q4_reg;
    logic [24:0]        ysum;
    logic [50:0]        mq4;
    logic signed [31:0] px4_reg [4];
    logic signed [31:0] py4_reg [4];
    logic signed [63:0] dpx4_reg [4];
    logic signed [63:0] dpy4_reg [4];

    assign mh4_next = 47'(cube3_reg[47:24]) * 47'(cbs_pkg::INV3_24);
    assign ysum     = 25'(cube3_reg[47:24]) + 25'(cube3_reg[23:0]);
    assign mq4      = 51'(ysum) * 51'(cbs_pkg::RECIP3_27);

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            f4_reg    <= f3_reg;
            z4_reg    <= z3_reg;
            sq4_reg   <= sq3_reg;
            cube4_reg <= cube3_reg;
            mh4_reg   <= mh4_next;
            q4_reg    <= mq4[50:27];
            for (int k = 0; k < 4; k++) begin
                px4_reg[k]  <= px3_reg[k];
                py4_reg[k]  <= py3_reg[k];
                dpx4_reg[k] <= 64'(c3_reg[k]) * 64'(px3_reg[k]);
                dpy4_reg[k] <= 64'(c3_reg[k]) * 64'(py3_reg[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: floor(f^3/3), dP/dt rounded to Q16.16
    // ------------------------------------------------------------------
    logic [15:0]        f5_reg;
    logic signed [31:0] z5_reg;
    logic [31:0]        sq5_reg;
    logic [47:0]        cube5_reg;
    logic [47:0]        fq5_reg;
    logic signed [35:0] dsx5_reg, dsy5_reg;
    logic signed [65:0] dax, day;
    logic signed [31:0] px5_reg [4];
    logic signed [31:0] py5_reg [4];

    always_comb begin
        dax = 66'(dpx4_reg[0]) + 66'(dpx4_reg[1]) + 66'(dpx4_reg[2]) + 66'(dpx4_reg[3]);
        day = 66'(dpy4_reg[0]) + 66'(dpy4_reg[1]) + 66'(dpy4_reg[2]) + 66'(dpy4_reg[3]);
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            f5_reg    <= f4_reg;
            z5_reg    <= z4_reg;
            sq5_reg   <= sq4_reg;
            cube5_reg <= cube4_reg;
            fq5_reg   <= 48'(mh4_reg) + 48'(q4_reg);
            dsx5_reg  <= 36'((dax + 66'sd536870912) >>> 30);
            dsy5_reg  <= 36'((day + 66'sd536870912) >>> 30);
            for (int k = 0; k < 4; k++) begin
                px5_reg[k] <= px4_reg[k];
                py5_reg[k] <= py4_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: position weights in Q30, derivative times n
    // b = floor((w/3 + 2^18) / 2^19), w the basis times 6*2^48
    // ------------------------------------------------------------------
    logic signed [31:0] z6_reg;
    logic [30:0]        b6_reg [4];
    logic [51:0]        fw, sqw, cw, fqw;
    logic [51:0]        aw [4];
    logic [51:0]        bw [4];
    logic [1:0]         rr;
    logic signed [47:0] dnx6_reg, dny6_reg;
    logic signed [47:0] nsx;
    logic signed [31:0] px6_reg [4];
    logic signed [31:0] py6_reg [4];

    always_comb begin
        fw  = 52'(f5_reg);
        sqw = 52'(sq5_reg);
        cw  = 52'(cube5_reg);
        fqw = 52'(fq5_reg);
        rr  = 2'(cw - fqw - (fqw << 1));
        // (1-t)^3 / 3 expanded around f^3 / 3
        aw[0] = cbs_pkg::K_ONE - fqw - 52'(rr == 2'd2) - (fw << 32) + (sqw << 16);
        aw[1] = cw - (sqw << 17) + cbs_pkg::K_FOUR;
        aw[2] = (sqw << 16) + (fw << 32) - cw + cbs_pkg::K_ONE;
        aw[3] = fqw;
        for (int k = 0; k < 4; k++) begin
            bw[k] = (aw[k] + 52'd262144) >> 19;
        end
        nsx = $signed({{(48 - NW){1'b0}}, n_reg});
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            z6_reg   <= z5_reg;
            dnx6_reg <= 48'(dsx5_reg) * nsx;
            dny6_reg <= 48'(dsy5_reg) * nsx;
            for (int k = 0; k < 4; k++) begin
                b6_reg[k]  <= bw[k][30:0];
                px6_reg[k] <= px5_reg[k];
                py6_reg[k] <= py5_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: position products; rate clamp and 1/(2 pi) in two halves
    // ------------------------------------------------------------------
    logic signed [31:0] z7_reg;
    logic signed [63:0] bpx7_reg [4];
    logic signed [63:0] bpy7_reg [4];
    logic signed [35:0] dcx, dcy;
    logic signed [17:0] dhx, dhy;
    logic signed [47:0] mhx7_reg, mhy7_reg;
    logic [47:0]        mlx7_reg, mly7_reg;

    always_comb begin
        if (dnx6_reg > 48'sd17179869184) begin
            dcx = 36'sd17179869184;
        end else if (dnx6_reg < -48'sd17179869184) begin
            dcx = -36'sd17179869184;
        end else begin
            dcx = 36'(dnx6_reg);
        end
        if (dny6_reg > 48'sd17179869184) begin
            dcy = 36'sd17179869184;
        end else if (dny6_reg < -48'sd17179869184) begin
            dcy = -36'sd17179869184;
        end else begin
            dcy = 36'(dny6_reg);
        end
        dhx = dcx[35:18];
        dhy = dcy[35:18];
    end

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            z7_reg   <= z6_reg;
            mhx7_reg <= 48'(dhx) * cbs_pkg::INV_TWO_PI;
            mhy7_reg <= 48'(dhy) * cbs_pkg::INV_TWO_PI;
            mlx7_reg <= 48'(dcx[17:0]) * 48'(cbs_pkg::INV_TWO_PI);
            mly7_reg <= 48'(dcy[17:0]) * 48'(cbs_pkg::INV_TWO_PI);
            for (int k = 0; k < 4; k++) begin
                bpx7_reg[k] <= 64'($signed({1'b0, b6_reg[k]})) * 64'(px6_reg[k]);
                bpy7_reg[k] <= 64'($signed({1'b0, b6_reg[k]})) * 64'(py6_reg[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: output register. Sums, rounding, saturation; an invalid
    // curve forces zeros and keeps height.
    // ------------------------------------------------------------------
    cbs_pkg::out_word_t m_data_reg, m_data_next;
    logic signed [65:0] psx, psy, slx, sly;

    always_comb begin
        psx = 66'(bpx7_reg[0]) + 66'(bpx7_reg[1]) + 66'(bpx7_reg[2]) + 66'(bpx7_reg[3]);
        psy = 66'(bpy7_reg[0]) + 66'(bpy7_reg[1]) + 66'(bpy7_reg[2]) + 66'(bpy7_reg[3]);
        slx = (66'(mhx7_reg) <<< 18) + $signed({18'b0, mlx7_reg});
        sly = (66'(mhy7_reg) <<< 18) + $signed({18'b0, mly7_reg});
        m_data_next.pos_z = z7_reg;
        if (cv_reg) begin
            m_data_next.pos_x   = cbs_pkg::sat32((psx + 66'sd536870912) >>> 30);
            m_data_next.pos_y   = cbs_pkg::sat32((psy + 66'sd536870912) >>> 30);
            m_data_next.slope_x = cbs_pkg::sat32((slx + 66'sd1073741824) >>> 31);
            m_data_next.slope_y = cbs_pkg::sat32((sly + 66'sd1073741824) >>> 31);
            m_data_next.curve_valid = 1'b1;
        end else begin
            m_data_next.pos_x   = '0;
            m_data_next.pos_y   = '0;
            m_data_next.slope_x = '0;
            m_data_next.slope_y = '0;
            m_data_next.curve_valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NST]) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_data = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CBS_ASSERT_NEXT(a_eval_enters, aclk, aresetn, acc_eval, v_reg[1],
        "accepted evaluate word missing from stage one")
    `CBS_ASSERT_NEXT(a_write_no_entry, aclk, aresetn,
        acc && (s_data.command == cbs_pkg::CMD_WRITE), !v_reg[1],
        "write word entered the evaluation pipeline")
    `CBS_ASSERT_NEXT(a_stage1_holds, aclk, aresetn, v_reg[1] && !en[2], v_reg[1],
        "stalled stage one word was dropped")
    `CBS_ASSERT_NEXT(a_cfg_clamp, aclk, aresetn, cfg_wr_en,
        (32'(n_reg) <= MAX_POINTS) && (cv_reg == (32'(n_reg) >= 32'd3)),
        "points in use out of range or valid flag mismatch")

endmodule

>>> verif/closed_bspline_evaluator_tb.sv
// ----------------------------------------------------------------------------
// Closed B-spline evaluator testbench
// Fills the control point ring, walks a directed table, then streams random
// write and evaluate words at several point counts under varied flow control.
// Each result is checked against a local fixed-point evaluator or a row's typed result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module closed_bspline_evaluator_tb;

    localparam int  RING_SLOTS  = 64;
    localparam int  SETTLE      = 16;       // pipeline depth plus margin
    localparam int  LIMIT       = 400000;   // cycle cap for the whole run
    localparam int  HOLD_CYCLES = 300;      // long receiver stall
    localparam int  SUB_ITEMS   = 80;       // words per random sub-phase

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [6:0]         cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    cbs_pkg::in_word_t  s_data;
    logic               m_valid;
    logic               m_ready;
    cbs_pkg::out_word_t m_data;

    closed_bspline_evaluator DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Local copy of what the block holds
    logic signed [31:0] ring_x [RING_SLOTS];
    logic signed [31:0] ring_y [RING_SLOTS];
    logic [6:0]         points_cfg;

    cbs_pkg::out_word_t pending_curve[$];
    int        mismatches;
    int        results_seen;
    int        evals_sent;
    int        writes_sent;
    int        cycles;

    // flow control knobs
    int send_idle;
    int recv_idle;
    int hold_reqs;
    int hold_seen;
    int hold_left;

    typedef struct {
        int                 npts;     // points_in_use for this row
        cbs_pkg::in_word_t  w;
        bit                 typed;    // expected result given in the row
        cbs_pkg::out_word_t want;
    } stim_row_t;

    stim_row_t stim_table[$];

    // ------------------------------------------------------------------
    // Fixed-point evaluator
    // ------------------------------------------------------------------
    function automatic logic signed [127:0] round_down(input logic signed [127:0] v,
                                                       input int s);
        return (v + (128'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [31:0] clip32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -128'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic cbs_pkg::out_word_t eval_curve(input cbs_pkg::in_word_t w);
        cbs_pkg::out_word_t r;
        longint unsigned nn, prod, seg, f, g, T, j;
        longint unsigned wt [4];
        logic signed [127:0] b [4];
        logic signed [127:0] c [4];
        logic signed [127:0] px [4];
        logic signed [127:0] py [4];
        logic signed [127:0] ax, ay, dx, dy, ns, fs, gs, ts, lim;
        r = '0;
        r.pos_z = w.height;
        nn = (points_cfg > RING_SLOTS) ? RING_SLOTS : points_cfg;
        if (nn < 3) return r;
        T    = 65536;
        prod = longint'(w.phase) * nn;
        seg  = prod >> 16;
        f    = prod & 64'hFFFF;
        g    = T - f;
        for (int k = 0; k < 4; k++) begin
            j = (seg + nn + k - 1) % nn;
            px[k] = ring_x[j];
            py[k] = ring_y[j];
        end
        // position basis scaled by 6 * 2^48, rounded to Q30
        wt[0] = g * g * g;
        wt[1] = 3 * f * f * f + 4 * T * T * T - 6 * f * f * T;
        wt[2] = 3 * f * f * T + 3 * f * T * T + T * T * T - 3 * f * f * f;
        wt[3] = f * f * f;
        for (int k = 0; k < 4; k++) b[k] = (wt[k] + 786432) / 1572864;
        // derivative basis in units of 2^-33
        fs = f; gs = g; ts = T;
        c[0] = round_down(-(gs * gs), 3);
        c[1] = round_down(3 * fs * fs - 4 * fs * ts, 3);
        c[2] = round_down(-3 * fs * fs + 2 * fs * ts + ts * ts, 3);
        c[3] = round_down(fs * fs, 3);
        ax = 0; ay = 0;
        for (int k = 0; k < 4; k++) begin
            ax += b[k] * px[k];
            ay += b[k] * py[k];
        end
        r.pos_x = clip32(round_down(ax, 30));
        r.pos_y = clip32(round_down(ay, 30));
        ax = 0; ay = 0;
        for (int k = 0; k < 4; k++) begin
            ax += c[k] * px[k];
            ay += c[k] * py[k];
        end
        ns  = nn;
        lim = 128'sd1 <<< 34;
        dx  = round_down(ax, 30) * ns;
        dy  = round_down(ay, 30) * ns;
        if (dx > lim) dx = lim;
        if (dx < -lim) dx = -lim;
        if (dy > lim) dy = lim;
        if (dy < -lim) dy = -lim;
        r.slope_x = clip32(round_down(dx * 128'sd341782638, 31));
        r.slope_y = clip32(round_down(dy * 128'sd341782638, 31));
        r.curve_valid = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        cbs_pkg::out_word_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_curve.size() == 0) begin
                report_mismatch("unexpected word", m_data.pos_z, 32'h0);
            end else begin
                e = pending_curve.pop_front();
                if (m_data.pos_x !== e.pos_x) report_mismatch("pos_x", m_data.pos_x, e.pos_x);
                if (m_data.pos_y !== e.pos_y) report_mismatch("pos_y", m_data.pos_y, e.pos_y);
                if (m_data.pos_z !== e.pos_z) report_mismatch("pos_z", m_data.pos_z, e.pos_z);
                if (m_data.slope_x !== e.slope_x)
                    report_mismatch("slope_x", m_data.slope_x, e.slope_x);
                if (m_data.slope_y !== e.slope_y)
                    report_mismatch("slope_y", m_data.slope_y, e.slope_y);
                if (m_data.curve_valid !== e.curve_valid)
                    report_mismatch("curve_valid", 32'(m_data.curve_valid),
                                    32'(e.curve_valid));
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[closed_bspline_evaluator] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    // Offer one word; valid stays up across back-to-back words and is only
    // dropped inside an idle gap.
    task automatic send_word(input cbs_pkg::in_word_t w, input bit typed,
                             input cbs_pkg::out_word_t want);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        if (w.command == cbs_pkg::CMD_WRITE) begin
            ring_x[w.point_index] = w.point_x;
            ring_y[w.point_index] = w.point_y;
            writes_sent++;
        end else begin
            pending_curve.insert(pending_curve.size(), typed ? want : eval_curve(w));
            evals_sent++;
        end
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_curve.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // points_in_use changes only with nothing in flight
    task automatic set_points(input logic [6:0] n);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        points_cfg  = n;
    endtask

    function automatic logic [31:0] pick_coord;
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic cbs_pkg::in_word_t pick_word(input int write_pct);
        cbs_pkg::in_word_t w;
        w.command     = ($urandom_range(0, 99) < write_pct) ? cbs_pkg::CMD_WRITE
                                                            : cbs_pkg::CMD_EVAL;
        w.point_index = 6'($urandom);
        w.point_x     = pick_coord();
        w.point_y     = pick_coord();
        w.phase       = 16'($urandom);
        w.height      = $urandom;
        return w;
    endfunction

    function automatic void add_row(input int n, input logic cmd, input int idx,
                                    input logic [31:0] x, input logic [31:0] y,
                                    input logic [15:0] ph, input logic [31:0] h,
                                    input bit typed);
        stim_row_t r;
        r.npts = n;
        r.w    = '{command: cmd, point_index: 6'(idx), point_x: x, point_y: y,
                   phase: ph, height: h};
        r.typed = typed;
        // only invalid-curve rows carry a typed result
        r.want  = '{pos_x: 32'h0, pos_y: 32'h0, pos_z: h, slope_x: 32'h0,
                    slope_y: 32'h0, curve_valid: 1'b0};
        stim_table.insert(stim_table.size(), r);
    endfunction

    logic [6:0]         rand_points;
    cbs_pkg::out_word_t none;

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        none        = '0;
        points_cfg  = '0;
        mismatches  = 0;
        results_seen = 0;
        evals_sent  = 0;
        writes_sent = 0;
        cycles      = 0;
        send_idle   = 0;
        recv_idle   = 0;
        hold_reqs   = 0;
        hold_seen   = 0;
        for (int i = 0; i < RING_SLOTS; i++) begin
            ring_x[i] = '0;
            ring_y[i] = '0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Invalid curve straight out of reset: no ring read yet
        add_row(0, cbs_pkg::CMD_EVAL, 0, 0, 0, 16'h0000, 32'h7FFF_FFFF, 1);
        add_row(0, cbs_pkg::CMD_EVAL, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                32'h8000_0000, 1);
        // Fill the whole ring so any later point count reads written slots
        for (int i = 0; i < RING_SLOTS; i++)
            add_row(0, cbs_pkg::CMD_WRITE, i, (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000,
                    (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF, 16'h0, 32'h0, 0);
        add_row(2, cbs_pkg::CMD_EVAL, 5, 0, 0, 16'hFFFF, 32'h0000_0000, 1);
        add_row(1, cbs_pkg::CMD_EVAL, 5, 0, 0, 16'h8000, 32'hFFFF_FFFF, 1);
        // Three points, all at the positive/negative corner
        add_row(3, cbs_pkg::CMD_WRITE, 0, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0, 32'h0, 0);
        add_row(3, cbs_pkg::CMD_WRITE, 1, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0, 32'h0, 0);
        add_row(3, cbs_pkg::CMD_WRITE, 2, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0, 32'h0, 0);
        add_row(3, cbs_pkg::CMD_EVAL, 0, 0, 0, 16'h0000, 32'h0001_0000, 0);
        add_row(3, cbs_pkg::CMD_EVAL, 0, 0, 0, 16'hFFFF, 32'h0001_0000, 0);
        add_row(3, cbs_pkg::CMD_EVAL, 0, 0, 0, 16'h8000, 32'h0001_0000, 0);
        // Sharp turn: opposite extremes next to each other
        add_row(3, cbs_pkg::CMD_WRITE, 0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 32'h0, 0);
        add_row(3, cbs_pkg::CMD_EVAL, 0, 0, 0, 16'h5555, 32'h0, 0);
        add_row(3, cbs_pkg::CMD_EVAL, 0, 0, 0, 16'hAAAA, 32'h0, 0);
        // Full ring of extreme points, phases at both ends of the range
        add_row(64, cbs_pkg::CMD_EVAL, 0, 0, 0, 16'h0000, 32'h0, 0);
        add_row(64, cbs_pkg::CMD_EVAL, 0, 0, 0, 16'hFFFF, 32'h0, 0);
        add_row(64, cbs_pkg::CMD_EVAL, 0, 0, 0, 16'h0001, 32'h0, 0);
        // Counts above the ring size act as a full ring
        add_row(127, cbs_pkg::CMD_EVAL, 0, 0, 0, 16'hFFFF, 32'h0, 0);
        add_row(127, cbs_pkg::CMD_EVAL, 0, 0, 0, 16'h1234, 32'h0, 0);
        add_row(1, cbs_pkg::CMD_EVAL, 0, 0, 0, 16'h4000, 32'h1234_5678, 1);

        foreach (stim_table[i]) begin
            if (stim_table[i].npts != points_cfg) set_points(7'(stim_table[i].npts));
            send_word(stim_table[i].w, stim_table[i].typed, stim_table[i].want);
        end

        // Random part: three flow-control modes, four point counts each
        for (int mode = 0; mode < 3; mode++) begin
            send_idle = (mode == 0) ? 7 : (mode == 1) ? 69 : 0;
            recv_idle = (mode == 0) ? 69 : (mode == 1) ? 7 : 0;
            for (int sp = 0; sp < 4; sp++) begin
                case ($urandom_range(0, 7))
                    0:       rand_points = 7'd3;
                    1:       rand_points = 7'd64;
                    2:       rand_points = 7'($urandom_range(65, 127));
                    3:       rand_points = 7'($urandom_range(0, 2));
                    default: rand_points = 7'($urandom_range(4, 63));
                endcase
                set_points(rand_points);
                for (int k = 0; k < SUB_ITEMS; k++) begin
                    // sender pause: let every result come home mid-stream
                    if (mode == 0 && sp == 1 && k == SUB_ITEMS / 2) begin
                        s_valid <= 1'b0;
                        @(posedge aclk);
                        while (pending_curve.size() != 0) @(posedge aclk);
                    end
                    // long receiver stall while words keep coming
                    if (mode == 2 && sp == 0 && k == 8) hold_reqs++;
                    send_word(pick_word(25), 0, none);
                end
            end
        end
        set_points(7'd0);
        drain();

        $display("covered %0d evaluate and %0d write words, %0d results checked",
                 evals_sent, writes_sent, results_seen);
        $display("point counts 0 to 127, flow control idle/stall mixes and a long hold-off");
        if (mismatches == 0 && pending_curve.size() == 0) begin
            $display("[closed_bspline_evaluator] OK");
        end else begin
            $display("[closed_bspline_evaluator] ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/cbs_pkg.sv
rtl/cbs_ram.sv
rtl/closed_bspline_evaluator.sv
verif/closed_bspline_evaluator_tb.sv
